FILE: sv/bti_pkg.sv
// Package with shared types and constants of the barycentric interpolator.
package bti_pkg;

    localparam int TableDepth = 1024;
    localparam int IdxW       = 10;
    localparam int CoordW     = 24;
    localparam int AttrW      = 16;
    localparam int WeightFrac = 16;
    localparam int DiffW      = CoordW + 1;
    localparam int ProdW      = 2 * DiffW;
    localparam int DetW       = ProdW + 1;
    localparam int QueueDepth = 2;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;
    localparam logic [2:0] TOUCH_VALID = 3'd3;

    typedef struct packed {
        logic                     req_type;
        logic [IdxW-1:0]          entry_index;
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic [AttrW-1:0]         elevation;
        logic [AttrW-1:0]         moisture;
        logic [IdxW-1:0]          vertex_a;
        logic [IdxW-1:0]          vertex_b;
        logic [IdxW-1:0]          vertex_c;
        logic [2:0]               touch_count;
    } bti_in_t;

    typedef struct packed {
        logic             inside_res;
        logic [AttrW-1:0] interp_elevation;
        logic [AttrW-1:0] interp_moisture;
    } bti_out_t;

    typedef struct packed {
        logic                     touch_ok;
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic [IdxW-1:0]          vertex_a;
        logic [IdxW-1:0]          vertex_b;
        logic [IdxW-1:0]          vertex_c;
    } bti_query_t;

endpackage

FILE: sv/barycentric_triangle_interpolator_unit.sv
// Top level of the barycentric triangle interpolator.
// Input channel in_valid/in_stall carries write and query items of type bti_in_t.
// A write item loads one vertex table entry and gives no result.
// A query item gives exactly one result item of type bti_out_t on out_valid/out_stall.
// Accepted queries enter a two-entry queue; the back part handles one at a time.
// A query that fails an early check gets its result straight from that check;
// a query inside its triangle goes on through the two 17-step bit-serial weight
// divisions and the three-step interpolation accumulate.
// The back part takes the next query in the cycle after the result is taken, so
// it does not start a new query before the last result has left.
// Writes are taken at one per cycle while no query is queued or reading the table.
// The result sits in an output register until taken; while the receiver
// stalls the back part holds the next query, and the input stalls once the
// queue is full.
// Reset clears the queue, the sequencer and the output register. The vertex
// table is not cleared: entries are undefined until written.
// Table reads are registered and go through a single read port.
// Results leave in the order the queries arrived.
module barycentric_triangle_interpolator_unit
    import bti_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  bti_in_t  in_item,
    output logic     out_valid,
    input  logic     out_stall,
    output bti_out_t out_item
);

    logic       wr_en, q_valid, q_take, tbl_busy;
    bti_in_t    wr_item;
    bti_query_t q_item;

    bti_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_item(in_item), .tbl_busy(tbl_busy), .wr_en(wr_en), .wr_item(wr_item),
        .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
    );

    bti_back u_back (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_item(wr_item),
        .q_valid(q_valid), .q_take(q_take), .q_item(q_item), .tbl_busy(tbl_busy),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

endmodule

FILE: sv/bti_front.sv
// Front part: accepts items, performs table writes and queues queries.
module bti_front
    import bti_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  bti_in_t    in_item,
    input  logic       tbl_busy,
    output logic       wr_en,
    output bti_in_t    wr_item,
    output logic       q_valid,
    input  logic       q_take,
    output bti_query_t q_item
);

    bti_query_t q_mem_reg [QueueDepth];
    logic       rd_ptr_reg, wr_ptr_reg, rd_ptr_next, wr_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       accept, push;
    bti_query_t push_item;

    // A write waits until every earlier query has read its vertices.
    assign in_stall = (count_reg == 2'(QueueDepth)) ||
                      ((in_item.req_type == REQ_WRITE) && ((count_reg != 2'd0) || tbl_busy));
    assign accept   = in_valid && !in_stall;
    assign push     = accept && (in_item.req_type == REQ_QUERY);
    assign wr_en    = accept && (in_item.req_type == REQ_WRITE);
    assign wr_item  = in_item;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        push_item.touch_ok = (in_item.touch_count == TOUCH_VALID);
        push_item.pos_x    = in_item.pos_x;
        push_item.pos_y    = in_item.pos_y;
        push_item.vertex_a = in_item.vertex_a;
        push_item.vertex_b = in_item.vertex_b;
        push_item.vertex_c = in_item.vertex_c;
        rd_ptr_next = rd_ptr_reg ^ q_take;
        wr_ptr_next = wr_ptr_reg ^ push;
        count_next  = count_reg + 2'(push) - 2'(q_take);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/bti_back.sv
// Back part: vertex table, geometry tests, weight division and interpolation.
module bti_back
    import bti_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  bti_in_t    wr_item,
    input  logic       q_valid,
    output logic       q_take,
    input  bti_query_t q_item,
    output logic       tbl_busy,
    output logic       out_valid,
    input  logic       out_stall,
    output bti_out_t   out_item
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_RDA   = 10'b0000000010,
        ST_RDB   = 10'b0000000100,
        ST_RDC   = 10'b0000001000,
        ST_DIFF  = 10'b0000010000,
        ST_MUL   = 10'b0000100000,
        ST_SUM   = 10'b0001000000,
        ST_CHECK = 10'b0010000000,
        ST_DIV   = 10'b0100000000,
        ST_MAC   = 10'b1000000000
    } st_t;

    logic [2*CoordW-1:0] pos_mem [TableDepth];
    logic [2*AttrW-1:0]  attr_mem [TableDepth];
    logic [2*CoordW-1:0] pos_rd_reg;
    logic [2*AttrW-1:0]  attr_rd_reg;
    logic [IdxW-1:0]     rd_addr;

    st_t        state_reg, state_next;
    bti_query_t qry_reg;
    logic signed [CoordW-1:0] vx_reg [3];
    logic signed [CoordW-1:0] vy_reg [3];
    logic [AttrW-1:0] ve_reg [3];
    logic [AttrW-1:0] vm_reg [3];
    logic signed [DiffW-1:0] d_reg [6];
    logic signed [ProdW-1:0] p_reg [6];
    logic signed [DetW-1:0]  det_reg, n1_reg, n2_reg;
    logic [DetW-1:0]  dabs_reg, rem_reg;
    logic [4:0]       bit_reg;
    logic             div_sel_reg;
    logic [WeightFrac:0] w1_reg, w2_reg, q_reg;
    logic [1:0]       mac_reg;
    logic [WeightFrac+AttrW+1:0] acc_e_reg, acc_m_reg;
    logic             bbox_out;
    logic             out_full_reg;
    bti_out_t         out_reg;

    assign out_valid = out_full_reg;
    assign out_item  = out_reg;
    assign q_take    = (state_reg == ST_IDLE) && q_valid && !out_full_reg;
    assign tbl_busy  = (state_reg == ST_RDA) || (state_reg == ST_RDB) || (state_reg == ST_RDC);

    always_comb
    begin
        unique case (state_reg)
            ST_RDA:  rd_addr = qry_reg.vertex_a;
            ST_RDB:  rd_addr = qry_reg.vertex_b;
            default: rd_addr = qry_reg.vertex_c;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[wr_item.entry_index]  <= {wr_item.pos_y, wr_item.pos_x};
            attr_mem[wr_item.entry_index] <= {wr_item.moisture, wr_item.elevation};
        end
        pos_rd_reg  <= pos_mem[rd_addr];
        attr_rd_reg <= attr_mem[rd_addr];
    end

    always_comb
    begin
        bbox_out =
            (qry_reg.pos_x > vx_reg[0] && qry_reg.pos_x > vx_reg[1]
                && qry_reg.pos_x > vx_reg[2]) ||
            (qry_reg.pos_y > vy_reg[0] && qry_reg.pos_y > vy_reg[1]
                && qry_reg.pos_y > vy_reg[2]) ||
            (qry_reg.pos_x < vx_reg[0] && qry_reg.pos_x < vx_reg[1]
                && qry_reg.pos_x < vx_reg[2]) ||
            (qry_reg.pos_y < vy_reg[0] && qry_reg.pos_y < vy_reg[1]
                && qry_reg.pos_y < vy_reg[2]);
    end

    logic [DetW-1:0] rem_sh;
    logic signed [DetW-1:0] n3_val;
    logic [AttrW-1:0] mac_e, mac_m;
    logic [WeightFrac:0] mac_w;
    logic [WeightFrac+AttrW+1:0] mac_pe, mac_pm;
    logic [1:0] vslot;
    logic signed [CoordW-1:0] cx, cy;
    logic reject;

    always_comb
    begin
        rem_sh = {rem_reg[DetW-2:0], 1'b0};
        n3_val = det_reg - n1_reg - n2_reg;
        cx = $signed(pos_rd_reg[CoordW-1:0]);
        cy = $signed(pos_rd_reg[2*CoordW-1:CoordW]);
        unique case (mac_reg)
            2'd0:    begin mac_w = w1_reg; mac_e = ve_reg[0]; mac_m = vm_reg[0]; end
            2'd1:    begin mac_w = w2_reg; mac_e = ve_reg[1]; mac_m = vm_reg[1]; end
            default: begin
                mac_w = (WeightFrac+1)'(1 << WeightFrac) - w1_reg - w2_reg;
                mac_e = ve_reg[2];
                mac_m = vm_reg[2];
            end
        endcase
        mac_pe = (WeightFrac+AttrW+2)'(mac_w) * (WeightFrac+AttrW+2)'(mac_e);
        mac_pm = (WeightFrac+AttrW+2)'(mac_w) * (WeightFrac+AttrW+2)'(mac_m);
        unique case (state_reg)
            ST_RDB:  vslot = 2'd0;
            ST_RDC:  vslot = 2'd1;
            default: vslot = 2'd2;
        endcase
        reject = !qry_reg.touch_ok || bbox_out || det_reg == '0 ||
            (det_reg[DetW-1] ?
                (n1_reg > 0 || n1_reg < det_reg || n2_reg > 0 ||
                 n2_reg < det_reg || n3_val > 0 || n3_val < det_reg) :
                (n1_reg < 0 || n1_reg > det_reg || n2_reg < 0 ||
                 n2_reg > det_reg || n3_val < 0 || n3_val > det_reg));
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (q_take)
                begin
                    qry_reg <= q_item;
                end
            end
            ST_RDB, ST_RDC, ST_DIFF:
            begin
                vx_reg[vslot] <= pos_rd_reg[CoordW-1:0];
                vy_reg[vslot] <= pos_rd_reg[2*CoordW-1:CoordW];
                ve_reg[vslot] <= attr_rd_reg[AttrW-1:0];
                vm_reg[vslot] <= attr_rd_reg[2*AttrW-1:AttrW];
            end
            ST_MUL:
            begin
                p_reg[0] <= d_reg[0] * d_reg[1];
                p_reg[1] <= d_reg[2] * d_reg[3];
                p_reg[2] <= d_reg[0] * d_reg[4];
                p_reg[3] <= d_reg[2] * d_reg[5];
                p_reg[4] <= d_reg[3] * d_reg[4];
                p_reg[5] <= d_reg[1] * d_reg[5];
            end
            ST_SUM:
            begin
                det_reg <= DetW'(p_reg[0]) + DetW'(p_reg[1]);
                n1_reg  <= DetW'(p_reg[2]) + DetW'(p_reg[3]);
                n2_reg  <= -DetW'(p_reg[4]) + DetW'(p_reg[5]);
            end
            ST_CHECK:
            begin
                if (det_reg[DetW-1])
                begin
                    det_reg <= -det_reg;
                    n1_reg  <= -n1_reg;
                    n2_reg  <= -n2_reg;
                end
                div_sel_reg <= 1'b0;
            end
            ST_DIV:
            begin
                if (bit_reg == 5'd0)
                begin
                    rem_reg <= div_sel_reg ? n2_reg : n1_reg;
                    dabs_reg <= det_reg;
                    q_reg <= '0;
                    if (div_sel_reg ? (n2_reg >= det_reg) : (n1_reg >= det_reg))
                    begin
                        rem_reg <= '0;
                        q_reg   <= (WeightFrac+1)'(1);
                    end
                end
                else
                begin
                    if (rem_sh >= dabs_reg)
                    begin
                        rem_reg <= rem_sh - dabs_reg;
                        q_reg   <= {q_reg[WeightFrac-1:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        q_reg   <= {q_reg[WeightFrac-1:0], 1'b0};
                    end
                    if (bit_reg == 5'(WeightFrac))
                    begin
                        div_sel_reg <= 1'b1;
                        if (!div_sel_reg)
                        begin
                            w1_reg <= (rem_sh >= dabs_reg) ?
                                {q_reg[WeightFrac-1:0], 1'b1} : {q_reg[WeightFrac-1:0], 1'b0};
                        end
                        else
                        begin
                            w2_reg <= (rem_sh >= dabs_reg) ?
                                {q_reg[WeightFrac-1:0], 1'b1} : {q_reg[WeightFrac-1:0], 1'b0};
                        end
                    end
                end
                acc_e_reg <= '0;
                acc_m_reg <= '0;
            end
            ST_MAC:
            begin
                acc_e_reg <= acc_e_reg + mac_pe;
                acc_m_reg <= acc_m_reg + mac_pm;
            end
            default:
            begin
            end
        endcase
        if (state_reg == ST_DIFF)
        begin
            d_reg[0] <= DiffW'(vy_reg[1]) - DiffW'(cy);
            d_reg[1] <= DiffW'(vx_reg[0]) - DiffW'(cx);
            d_reg[2] <= DiffW'(cx) - DiffW'(vx_reg[1]);
            d_reg[3] <= DiffW'(vy_reg[0]) - DiffW'(cy);
            d_reg[4] <= DiffW'(qry_reg.pos_x) - DiffW'(cx);
            d_reg[5] <= DiffW'(qry_reg.pos_y) - DiffW'(cy);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_take) state_next = ST_RDA;
            ST_RDA:   state_next = ST_RDB;
            ST_RDB:   state_next = ST_RDC;
            ST_RDC:   state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_CHECK;
            ST_CHECK: state_next = reject ? ST_IDLE : ST_DIV;
            ST_DIV:
            begin
                if (bit_reg == 5'(WeightFrac) && div_sel_reg)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:   if (mac_reg == 2'd2) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            out_full_reg <= 1'b0;
            bit_reg      <= 5'd0;
            mac_reg      <= 2'd0;
            out_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_full_reg && !out_stall)
            begin
                out_full_reg <= 1'b0;
            end
            if (state_reg == ST_DIV)
            begin
                bit_reg <= (bit_reg == 5'(WeightFrac)) ? 5'd0 : bit_reg + 5'd1;
            end
            if (state_reg == ST_MAC)
            begin
                mac_reg <= (mac_reg == 2'd2) ? 2'd0 : mac_reg + 2'd1;
            end
            if (state_reg == ST_CHECK && reject)
            begin
                out_reg      <= '0;
                out_full_reg <= 1'b1;
            end
            if (state_reg == ST_MAC && mac_reg == 2'd2)
            begin
                out_reg.inside_res       <= 1'b1;
                out_reg.interp_elevation <= AttrW'((acc_e_reg + mac_pe) >> WeightFrac);
                out_reg.interp_moisture  <= AttrW'((acc_m_reg + mac_pm) >> WeightFrac);
                out_full_reg <= 1'b1;
            end
        end
    end

endmodule

FILE: sv/bti_checker.sv
// Port-level checker for the barycentric interpolator and its bind.
module bti_checker
    import bti_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input bti_out_t out_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result item changed while stalled");

    a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.inside_res |->
            out_item.interp_elevation == '0 && out_item.interp_moisture == '0)
        else $error("result outside triangle carries values");

    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !$isunknown(in_stall))
        else $error("input stall unknown while an item is offered");

    a_reset_clear: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid straight after reset");

endmodule

bind barycentric_triangle_interpolator_unit bti_checker u_bti_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);

FILE: tb/barycentric_triangle_interpolator_unit_tb.sv
// Testbench for the barycentric triangle interpolator: table writes and queries checked against a predictor.
`timescale 1ns / 100ps

module barycentric_triangle_interpolator_unit_tb;
    import bti_pkg::*;

    localparam int StallLimit = 20000;
    localparam int HoldLength = 400;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    bti_in_t  in_item;
    logic     out_valid;
    logic     out_stall;
    bti_out_t out_item;

    barycentric_triangle_interpolator_unit uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
        .out_item(out_item)
    );

    bti_in_t  pending_items[$];
    bti_out_t expected_results[$];
    logic [2*CoordW-1:0] site_pos[TableDepth];
    logic [2*AttrW-1:0]  site_attr[TableDepth];
    bit                  site_loaded[TableDepth];
    int loaded_sites[$];
    int sender_idle_pct;
    int receiver_idle_pct;
    int hold_cycles = 0;
    bit hold_request = 1'b0;
    bit hold_seen = 1'b0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned weight_quotient(longint unsigned num,
                                                        longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = num;
        if (r >= den)
        begin
            q = 1;
            r -= den;
        end
        for (int i = 0; i < WeightFrac; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r -= den;
                q |= 1;
            end
        end
        return q;
    endfunction

    function automatic bit wholly_beyond(longint p, longint a, longint b, longint c);
        return (p > a && p > b && p > c) || (p < a && p < b && p < c);
    endfunction

    function automatic bti_out_t interpolate_query(bti_in_t q);
        bti_out_t r;
        longint px, py, x1, y1, x2, y2, x3, y3, det, n1, n2, n3;
        longint unsigned w1, w2, w3;
        logic [2*AttrW-1:0] a1, a2, a3;
        int ia, ib, ic;
        r = '0;
        ia = q.vertex_a;
        ib = q.vertex_b;
        ic = q.vertex_c;
        if (q.touch_count != TOUCH_VALID)
            return r;
        px = q.pos_x;
        py = q.pos_y;
        x1 = $signed(site_pos[ia][CoordW-1:0]);
        y1 = $signed(site_pos[ia][2*CoordW-1:CoordW]);
        x2 = $signed(site_pos[ib][CoordW-1:0]);
        y2 = $signed(site_pos[ib][2*CoordW-1:CoordW]);
        x3 = $signed(site_pos[ic][CoordW-1:0]);
        y3 = $signed(site_pos[ic][2*CoordW-1:CoordW]);
        if (wholly_beyond(px, x1, x2, x3) || wholly_beyond(py, y1, y2, y3))
            return r;
        det = (y2 - y3) * (x1 - x3) + (x3 - x2) * (y1 - y3);
        if (det == 0)
            return r;
        n1 = (y2 - y3) * (px - x3) + (x3 - x2) * (py - y3);
        n2 = (y3 - y1) * (px - x3) + (x1 - x3) * (py - y3);
        if (det < 0)
        begin
            det = -det;
            n1 = -n1;
            n2 = -n2;
        end
        n3 = det - n1 - n2;
        if (n1 < 0 || n1 > det || n2 < 0 || n2 > det || n3 < 0 || n3 > det)
            return r;
        w1 = weight_quotient(n1, det);
        w2 = weight_quotient(n2, det);
        w3 = (64'd1 << WeightFrac) - w1 - w2;
        a1 = site_attr[ia];
        a2 = site_attr[ib];
        a3 = site_attr[ic];
        r.inside_res = 1'b1;
        r.interp_elevation = AttrW'((w1 * a1[15:0] + w2 * a2[15:0] + w3 * a3[15:0])
                                    >> WeightFrac);
        r.interp_moisture = AttrW'((w1 * a1[31:16] + w2 * a2[31:16] + w3 * a3[31:16])
                                   >> WeightFrac);
        return r;
    endfunction

    function automatic logic [CoordW-1:0] random_coord();
        case ($urandom_range(0, 3))
            0: return CoordW'($urandom);
            1: return CoordW'($signed($urandom_range(0, 4000)) - 2000);
            default: return CoordW'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    task automatic add_site(int idx, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                            logic [AttrW-1:0] e, logic [AttrW-1:0] m);
        bti_in_t w;
        w = '0;
        w.req_type = REQ_WRITE;
        w.entry_index = IdxW'(idx);
        w.pos_x = x;
        w.pos_y = y;
        w.elevation = e;
        w.moisture = m;
        w.vertex_a = IdxW'($urandom);
        w.vertex_b = IdxW'($urandom);
        w.vertex_c = IdxW'($urandom);
        w.touch_count = 3'($urandom);
        pending_items.push_back(w);
        if (!site_loaded[idx])
            loaded_sites.push_back(idx);
        site_loaded[idx] = 1'b1;
    endtask

    task automatic add_query(int a, int b, int c, logic [CoordW-1:0] x,
                             logic [CoordW-1:0] y, logic [2:0] touch);
        bti_in_t q;
        q = '0;
        q.req_type = REQ_QUERY;
        q.entry_index = IdxW'($urandom);
        q.elevation = AttrW'($urandom);
        q.moisture = AttrW'($urandom);
        q.vertex_a = IdxW'(a);
        q.vertex_b = IdxW'(b);
        q.vertex_c = IdxW'(c);
        q.pos_x = x;
        q.pos_y = y;
        q.touch_count = touch;
        pending_items.push_back(q);
    endtask

    function automatic int any_site();
        return loaded_sites[$urandom_range(0, loaded_sites.size() - 1)];
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    // Driver: payload and valid change on the falling edge only.
    always @(negedge clk)
    begin
        if (in_valid && in_stall)
        begin
        end
        else if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
        begin
            in_item <= pending_items.pop_front();
            in_valid <= 1'b1;
        end
        else
        begin
            in_valid <= 1'b0;
            in_item <= bti_in_t'($bits(bti_in_t)'({$urandom, $urandom, $urandom,
                                                   $urandom}));
        end
    end

    // Receiver: random stalls, and one long hold counted here.
    always @(negedge clk)
    begin
        if (hold_request && !hold_seen)
        begin
            hold_seen <= 1'b1;
            hold_cycles <= HoldLength - 1;
            out_stall <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end

    // Monitor: predicts on accepted input and checks each accepted result.
    always @(posedge clk)
    begin
        bti_out_t exp_r;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (in_valid && !in_stall)
            begin
                if (in_item.req_type == REQ_WRITE)
                begin
                    site_pos[in_item.entry_index] = {in_item.pos_y, in_item.pos_x};
                    site_attr[in_item.entry_index] = {in_item.moisture, in_item.elevation};
                end
                else
                    expected_results.push_back(interpolate_query(in_item));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result item %p", out_item);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (out_item !== exp_r)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Mismatch: expected %p, got %p", exp_r, out_item);
                    end
                end
            end
            if (quiet_cycles >= StallLimit)
            begin
                $display("FAIL barycentric_triangle_interpolator_unit");
                $finish;
            end
        end
    end

    initial
    begin
        int a, b, c, n;
        logic [CoordW-1:0] x, y;
        in_valid = 1'b0;
        in_item = '0;
        rst_n = 1'b0;
        sender_idle_pct = 21;
        receiver_idle_pct = 62;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extreme coordinates and attributes, edges, vertices, degenerate.
        add_site(0, 24'h000000, 24'h000000, 16'h0000, 16'hFFFF);
        add_site(1, 24'h000A00, 24'h000000, 16'hFFFF, 16'h0000);
        add_site(2, 24'h000000, 24'h000A00, 16'h8000, 16'h1234);
        add_site(1023, 24'h7FFFFF, 24'h800000, 16'hFFFF, 16'hFFFF);
        add_site(1022, 24'h800000, 24'h7FFFFF, 16'hFFFF, 16'hFFFF);
        add_site(1021, 24'h800000, 24'h800000, 16'h0000, 16'h0000);
        add_site(3, 24'h001400, 24'h000000, 16'h4321, 16'hABCD);
        add_query(0, 1, 2, 24'h000200, 24'h000300, TOUCH_VALID);
        add_query(0, 1, 2, 24'h000000, 24'h000000, TOUCH_VALID);
        add_query(0, 1, 2, 24'h000500, 24'h000500, TOUCH_VALID);
        add_query(0, 1, 2, 24'h000500, 24'h000000, TOUCH_VALID);
        add_query(0, 1, 2, 24'h000900, 24'h000900, TOUCH_VALID);
        add_query(0, 1, 2, 24'hFFFF00, 24'h000100, TOUCH_VALID);
        add_query(0, 1, 2, 24'h000200, 24'h000300, 3'd0);
        add_query(0, 1, 2, 24'h000200, 24'h000300, 3'd7);
        add_query(0, 0, 2, 24'h000000, 24'h000100, TOUCH_VALID);
        add_query(0, 1, 3, 24'h000500, 24'h000000, TOUCH_VALID);
        add_query(1023, 1022, 1021, 24'h000000, 24'h000000, TOUCH_VALID);
        add_query(1023, 1022, 1021, 24'h800000, 24'h800000, TOUCH_VALID);
        add_query(1023, 1022, 1021, 24'h7FFFFF, 24'h7FFFFF, TOUCH_VALID);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 62 : 0;
            receiver_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 21 : 0;
            if (phase == 2)
                hold_request = 1'b1;
            for (int i = 0; i < 330; i++)
            begin
                n = $urandom_range(0, 9);
                if (n < 3 || loaded_sites.size() < 3)
                    add_site($urandom_range(0, TableDepth - 1), random_coord(),
                             random_coord(), AttrW'($urandom), AttrW'($urandom));
                else
                begin
                    a = any_site();
                    b = any_site();
                    c = any_site();
                    // Mostly points drawn inside the triangle's box so weights get tested.
                    if (n < 8)
                    begin
                        x = site_pos[a][CoordW-1:0];
                        y = site_pos[a][2*CoordW-1:CoordW];
                        case ($urandom_range(0, 3))
                            0: begin
                                x = site_pos[b][CoordW-1:0];
                                y = site_pos[c][2*CoordW-1:CoordW];
                            end
                            1: begin
                                x = CoordW'(($signed(site_pos[a][CoordW-1:0])
                                    + $signed(site_pos[b][CoordW-1:0])
                                    + $signed(site_pos[c][CoordW-1:0])) / 3);
                                y = CoordW'(($signed(site_pos[a][2*CoordW-1:CoordW])
                                    + $signed(site_pos[b][2*CoordW-1:CoordW])
                                    + $signed(site_pos[c][2*CoordW-1:CoordW])) / 3);
                            end
                            2: begin
                                x = CoordW'(($signed(site_pos[a][CoordW-1:0])
                                    + $signed(site_pos[b][CoordW-1:0])) / 2);
                                y = CoordW'(($signed(site_pos[a][2*CoordW-1:CoordW])
                                    + $signed(site_pos[b][2*CoordW-1:CoordW])) / 2);
                            end
                            default: ;
                        endcase
                        add_query(a, b, c, x, y,
                                  ($urandom_range(0, 9) == 0) ? 3'($urandom) : TOUCH_VALID);
                    end
                    else
                        add_query(a, b, c, random_coord(), random_coord(), 3'($urandom));
                end
            end
            wait_drained();
            while (expected_results.size() != 0)
                @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS barycentric_triangle_interpolator_unit");
        else
            $display("FAIL barycentric_triangle_interpolator_unit");
        $finish;
    end

endmodule
